// File: src/pot_pkg.sv
// ----------------------------------------------------------------------------
// pot_pkg
// shared types, widths and helpers of the perceptron online trainer
// ----------------------------------------------------------------------------
package pot_pkg;

    localparam int FEAT_W     = 16;
    localparam int LR_W       = 16;
    localparam int FC_W       = 5;
    localparam int WEIGHT_W   = 32;
    localparam int ACC_W      = 56;
    localparam int MUL_A_W    = 17;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int SAT_IN_W   = 49;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FC_W-1:0] FC_RESET = 5'd16;
    localparam logic [LR_W-1:0] LR_RESET = 16'd6554;

    typedef enum logic [1:0] {
        CMD_TRAIN   = 2'd0,
        CMD_PREDICT = 2'd1,
        CMD_CLEAR   = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FEATURE_COUNT = 2'd0,
        REG_LEARNING_RATE = 2'd1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_FIN,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_WR
    } t_state;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [FEAT_W-1:0] feature;
        logic                     label;
    } t_in_item;

    typedef struct packed {
        logic                       predicted_class;
        logic                       weights_updated;
        logic signed [WEIGHT_W-1:0] activation;
    } t_out_item;

    typedef struct packed {
        logic in_ready;
        logic mac_mul;
        logic acc_en;
        logic fin;
        logic upd_rd;
        logic upd_mul;
        logic upd_wr;
    } t_ctrl;

    typedef struct packed {
        logic go;
        logic row_end;
        logic train_miss;
        logic out_free;
        logic upd_last;
    } t_status;

    function automatic logic signed [WEIGHT_W-1:0] sat32(
        input logic signed [SAT_IN_W-1:0] v
    );
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'(32'sh7fff_ffff);
        lo = -SAT_IN_W'(32'sh7fff_ffff) - SAT_IN_W'(1);
        if (v > hi) begin
            return 32'sh7fff_ffff;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[WEIGHT_W-1:0];
    endfunction

endpackage

// File: src/pot_stream_if.sv
// ----------------------------------------------------------------------------
// pot_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface pot_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: src/perceptron_online_trainer.sv
// ----------------------------------------------------------------------------
// perceptron_online_trainer
// online perceptron: one feature element per transaction, one result per row
//
//   channel    dir  payload                                       handshake
//   i_item     in   cmd, feature, label                           valid/ready
//   o_result   out  predicted_class, weights_updated, activation  valid/ready
//   i_cfg_*    in   register index, data                          write enable
//
// each element goes through weight read, multiply and accumulate on the
// one shared multiplier; a row end adds a finish state, and a training miss
// then walks the stored row (read, multiply, write) through the same multiplier.
// a result waits in the output register while the next element is taken;
// a row end stalls only while that register is still full.
// reset is synchronous; weights read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module perceptron_online_trainer #(
    parameter int MAX_FEATURES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pot_stream_if.sink                       i_item,
    pot_stream_if.source                     o_result,
    input  logic                             i_cfg_we,
    input  logic [pot_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pot_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pot_pkg::*;

    localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CNT_W = $clog2(MAX_FEATURES + 1);
    localparam int CMP_W = (CNT_W > FC_W) ? CNT_W : FC_W;
    localparam int STEP_W = PROD_W - 8;

    t_ctrl   ctrl;
    t_status status;

    logic [FC_W-1:0]            r_fc;
    logic [LR_W-1:0]            r_lr;
    logic [CNT_W-1:0]           r_cnt;
    logic [IDX_W-1:0]           r_idx;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [WEIGHT_W-1:0] r_bias;
    logic [MAX_FEATURES-1:0]    r_wvalid;
    logic                       r_wv_q;
    logic signed [FEAT_W-1:0]   r_feat;
    logic [1:0]                 r_cmd;
    logic                       r_label;
    logic [IDX_W-1:0]           r_upd_idx;
    t_out_item                  r_out;
    logic                       r_out_valid;

    logic                       accept;
    logic                       clear;
    logic [IDX_W-1:0]           idx_in;
    logic [CNT_W-1:0]           cnt_next;
    logic [CMP_W-1:0]           fc_x;
    logic [CMP_W-1:0]           max_x;
    logic [CMP_W-1:0]           eff;
    logic                       w_re;
    logic [IDX_W-1:0]           w_raddr;
    logic [WEIGHT_W-1:0]        w_rdata;
    logic signed [WEIGHT_W-1:0] w_cur;
    logic [FEAT_W-1:0]          row_rdata;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SAT_IN_W-1:0] act_sum;
    logic signed [WEIGHT_W-1:0] act;
    logic                       pred;
    logic signed [STEP_W-1:0]   step;
    logic signed [SAT_IN_W-1:0] w_sum;
    logic signed [WEIGHT_W-1:0] w_new;
    logic signed [SAT_IN_W-1:0] b_sum;

    assign i_item.ready = ctrl.in_ready;
    assign accept = i_item.valid && ctrl.in_ready;
    assign clear  = accept && (i_item.payload.cmd == CMD_CLEAR);

    assign status.go = accept && ((i_item.payload.cmd == CMD_TRAIN) ||
                                  (i_item.payload.cmd == CMD_PREDICT));

    assign idx_in = (r_cnt >= CNT_W'(MAX_FEATURES)) ? IDX_W'(MAX_FEATURES - 1)
                                                    : r_cnt[IDX_W-1:0];

    assign cnt_next = CNT_W'(r_idx) + CNT_W'(1);
    assign fc_x     = CMP_W'(r_fc);
    assign max_x    = CMP_W'(MAX_FEATURES);
    assign eff      = (r_fc == '0) ? CMP_W'(1) : ((fc_x > max_x) ? max_x : fc_x);
    assign status.row_end = CMP_W'(cnt_next) >= eff;

    assign act_sum = SAT_IN_W'(signed'(r_acc[ACC_W-1:8])) + SAT_IN_W'(r_bias);
    assign act     = sat32(act_sum);
    assign pred    = !act[WEIGHT_W-1];
    assign status.train_miss = (r_cmd == CMD_TRAIN) && (r_label != pred);
    assign status.out_free   = !r_out_valid || o_result.ready;
    assign status.upd_last   = (r_upd_idx == r_idx);

    assign w_re    = status.go || ctrl.upd_rd;
    assign w_raddr = ctrl.upd_rd ? r_upd_idx : idx_in;
    assign w_cur   = r_wv_q ? signed'(w_rdata) : '0;

    assign mul_a = ctrl.upd_mul ? signed'({1'b0, r_lr}) : MUL_A_W'(r_feat);
    assign mul_b = ctrl.upd_mul ? MUL_B_W'(signed'(row_rdata)) : w_cur;

    assign step  = prod[PROD_W-1:8];
    assign w_sum = r_label ? (SAT_IN_W'(w_cur) + SAT_IN_W'(step))
                           : (SAT_IN_W'(w_cur) - SAT_IN_W'(step));
    assign w_new = sat32(w_sum);
    assign b_sum = r_label ? (SAT_IN_W'(r_bias) + SAT_IN_W'({1'b0, r_lr}))
                           : (SAT_IN_W'(r_bias) - SAT_IN_W'({1'b0, r_lr}));

    pot_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    pot_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (ctrl.mac_mul || ctrl.upd_mul),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    pot_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAX_FEATURES),
        .AW    (IDX_W)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl.upd_wr),
        .i_waddr (r_upd_idx),
        .i_wdata (w_new),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pot_ram #(
        .WIDTH (FEAT_W),
        .DEPTH (MAX_FEATURES),
        .AW    (IDX_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (status.go),
        .i_waddr (idx_in),
        .i_wdata (i_item.payload.feature),
        .i_re    (ctrl.upd_rd),
        .i_raddr (r_upd_idx),
        .o_rdata (row_rdata)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc <= FC_RESET;
            r_lr <= LR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FEATURE_COUNT: r_fc <= i_cfg_data[FC_W-1:0];
                REG_LEARNING_RATE: r_lr <= i_cfg_data[LR_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_acc       <= '0;
            r_bias      <= '0;
            r_wvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_result.valid && o_result.ready && !(ctrl.fin && status.out_free)) begin
                r_out_valid <= 1'b0;
            end
            if (clear) begin
                r_cnt    <= '0;
                r_acc    <= '0;
                r_bias   <= '0;
                r_wvalid <= '0;
            end
            if (ctrl.acc_en) begin
                r_acc <= r_acc + ACC_W'(prod);
                r_cnt <= cnt_next;
            end
            if (ctrl.fin && status.out_free) begin
                r_out_valid <= 1'b1;
                r_acc       <= '0;
                r_cnt       <= '0;
                if (status.train_miss) begin
                    r_bias <= sat32(b_sum);
                end
            end
            if (ctrl.upd_wr) begin
                r_wvalid[r_upd_idx] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (status.go) begin
            r_feat  <= i_item.payload.feature;
            r_cmd   <= i_item.payload.cmd;
            r_label <= i_item.payload.label;
            r_idx   <= idx_in;
        end
        if (w_re) begin
            r_wv_q <= r_wvalid[w_raddr];
        end
        if (ctrl.fin && status.out_free) begin
            r_out.predicted_class <= pred;
            r_out.weights_updated <= status.train_miss;
            r_out.activation      <= act;
            r_upd_idx             <= '0;
        end else if (ctrl.upd_wr) begin
            r_upd_idx <= r_upd_idx + IDX_W'(1);
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_FEATURES))
        else $error("element count beyond row capacity");

    a_class_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |->
            (o_result.payload.predicted_class == !o_result.payload.activation[WEIGHT_W-1]))
        else $error("predicted class disagrees with activation sign");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear |=> (r_cnt == '0) && (r_acc == '0) && (r_bias == '0) && (r_wvalid == '0))
        else $error("clear transaction left state behind");

    a_upd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.upd_wr |-> (r_upd_idx <= r_idx))
        else $error("weight update past last row element");
endmodule

// File: src/pot_ram.sv
// ----------------------------------------------------------------------------
// pot_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pot_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/pot_mul.sv
// ----------------------------------------------------------------------------
// pot_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module pot_mul (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [pot_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [pot_pkg::MUL_B_W-1:0] i_b,
    output logic signed [pot_pkg::PROD_W-1:0]  o_prod
);
    import pot_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;
endmodule

// File: src/pot_seq.sv
// ----------------------------------------------------------------------------
// pot_seq
// sequencer: element mac, row finish and weight update walk
// ----------------------------------------------------------------------------
module pot_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pot_pkg::t_status i_status,
    output pot_pkg::t_ctrl   o_ctrl
);
    import pot_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_status.go) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = i_status.row_end ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    n_state = i_status.train_miss ? ST_UPD_RD : ST_IDLE;
                end
            end
            ST_UPD_RD: begin
                n_state = ST_UPD_MUL;
            end
            ST_UPD_MUL: begin
                n_state = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                n_state = i_status.upd_last ? ST_IDLE : ST_UPD_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            ST_IDLE:    o_ctrl.in_ready = 1'b1;
            ST_MUL:     o_ctrl.mac_mul  = 1'b1;
            ST_ACC:     o_ctrl.acc_en   = 1'b1;
            ST_FIN:     o_ctrl.fin      = 1'b1;
            ST_UPD_RD:  o_ctrl.upd_rd   = 1'b1;
            ST_UPD_MUL: o_ctrl.upd_mul  = 1'b1;
            ST_UPD_WR:  o_ctrl.upd_wr   = 1'b1;
            default:    o_ctrl = '0;
        endcase
    end
endmodule
